@@ sv/arpr_pkg.sv @@
// ----------------------------------------------------------------------------
// arpr_pkg: shared types and constants of the ARP resolver
// Widths, codes, FSM states and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package arpr_pkg;

	localparam int CACHE_DEPTH = 64;
	localparam int WAIT_DEPTH  = 16;
	localparam int NUM_PORTS   = 4;

	localparam int CIDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int WIDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

	localparam int ACT_W  = 2;
	localparam int NOW_W  = 32;
	localparam int PORT_W = 2;
	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int OP_W   = 16;
	localparam int TAG_W  = 16;
	localparam int KIND_W = 3;
	localparam int TRY_W  = 4;
	localparam int LIFE_W = 16;
	localparam int IVL_W  = 8;
	localparam int CFGI_W = 2;
	localparam int CFGD_W = 16;

	localparam logic [LIFE_W-1:0] LIFETIME_RST = 16'd300;
	localparam logic [TRY_W-1:0]  LIMIT_RST    = 4'd3;
	localparam logic [IVL_W-1:0]  INTERVAL_RST = 8'd1;

	// action codes
	localparam logic [ACT_W-1:0] ACT_RX   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TX   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

	// ARP operations
	localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;
	localparam logic [OP_W-1:0] OP_REPLY   = 16'd2;

	// result kinds
	localparam logic [KIND_W-1:0] K_NONE      = 3'd0;
	localparam logic [KIND_W-1:0] K_REPLY     = 3'd1;
	localparam logic [KIND_W-1:0] K_REQUEST   = 3'd2;
	localparam logic [KIND_W-1:0] K_SEND_NOW  = 3'd3;
	localparam logic [KIND_W-1:0] K_QUEUED    = 3'd4;
	localparam logic [KIND_W-1:0] K_DROP_FULL = 3'd5;
	localparam logic [KIND_W-1:0] K_DROP_UNRES = 3'd6;

	// register indexes
	localparam logic [CFGI_W-1:0] REG_LIFETIME = 2'd0;
	localparam logic [CFGI_W-1:0] REG_LIMIT    = 2'd1;
	localparam logic [CFGI_W-1:0] REG_INTERVAL = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [NOW_W-1:0]  now;
		logic [PORT_W-1:0] port;
		logic [IP_W-1:0]   port_ip;
		logic [IP_W-1:0]   peer_ip;
		logic [MAC_W-1:0]  peer_mac;
		logic [IP_W-1:0]   wanted_ip;
		logic [OP_W-1:0]   opcode;
		logic              item_ok;
		logic [TAG_W-1:0]  packet_tag;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PORT_W-1:0] port;
		logic [MAC_W-1:0]  mac;
		logic [IP_W-1:0]   ip;
		logic [TAG_W-1:0]  tag;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		logic [NOW_W-1:0] seen;
	} centry_t;

	typedef enum logic [2:0] {
		E_NONE,
		E_REPLY,
		E_HIT,
		E_QUEUED,
		E_FULL,
		E_REQ,
		E_WAIT
	} emit_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CSCAN,
		S_CDONE,
		S_RESP,
		S_HIT,
		S_WSEND,
		S_WREQ,
		S_WSCAN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic      scan_start;
		logic      cache_write;
		logic      w_step;
		logic      finish;
		emit_sel_t emit_sel;
	} cmd_t;

	typedef struct packed {
		logic is_rx;
		logic is_tx;
		logic is_tick;
		logic peer_nz;
		logic req_me;
		logic is_reply;
		logic scan_done;
		logic hit;
		logic wq_free;
		logic wq_req;
		logic w_last;
		logic w_go;
		logic emit_ok;
		logic push_ok;
	} sts_t;

endpackage

@@ sv/arpr_ifs.sv @@
// ----------------------------------------------------------------------------
// arpr_ifs: channel interfaces of the ARP resolver
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface arpr_pkt_if;
	import arpr_pkg::*;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [NOW_W-1:0]  now;
	logic [PORT_W-1:0] port;
	logic [IP_W-1:0]   port_ip;
	logic [IP_W-1:0]   peer_ip;
	logic [MAC_W-1:0]  peer_mac;
	logic [IP_W-1:0]   wanted_ip;
	logic [OP_W-1:0]   opcode;
	logic              item_ok;
	logic [TAG_W-1:0]  packet_tag;
	modport source (output valid, action, now, port, port_ip, peer_ip, peer_mac,
		wanted_ip, opcode, item_ok, packet_tag, input ready);
	modport sink (input valid, action, now, port, port_ip, peer_ip, peer_mac,
		wanted_ip, opcode, item_ok, packet_tag, output ready);
endinterface

interface arpr_res_if;
	import arpr_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [PORT_W-1:0] out_port;
	logic [MAC_W-1:0]  dest_mac;
	logic [IP_W-1:0]   about_ip;
	logic [TAG_W-1:0]  out_tag;
	logic              last;
	modport source (output valid, kind, out_port, dest_mac, about_ip, out_tag, last,
		input ready);
	modport sink (input valid, kind, out_port, dest_mac, about_ip, out_tag, last,
		output ready);
endinterface

interface arpr_cfg_if;
	import arpr_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFGI_W-1:0] index;
	logic [CFGD_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/arpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// arpr_ctrl: sequencing FSM of the ARP resolver
// Steps one item through cache scan, queue scan and result emission.
// ----------------------------------------------------------------------------
module arpr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pkt_valid,
	output logic          pkt_ready,
	input  arpr_pkg::sts_t sts,
	output arpr_pkg::cmd_t cmd
);
	import arpr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.emit_sel = E_NONE;
		pkt_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				pkt_ready = 1'b1;
				if (pkt_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (sts.is_rx) begin
					if (sts.peer_nz) begin
						cmd.scan_start = 1'b1;
						state_d = S_CSCAN;
					end else begin
						state_d = S_RESP;
					end
				end else if (sts.is_tx) begin
					cmd.scan_start = 1'b1;
					state_d = S_CSCAN;
				end else if (sts.is_tick) begin
					state_d = S_WSCAN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_CSCAN: begin
				if (sts.scan_done) state_d = S_CDONE;
			end
			S_CDONE: begin
				if (sts.is_rx) begin
					cmd.cache_write = 1'b1;
					state_d = S_RESP;
				end else if (sts.is_tx) begin
					state_d = sts.hit ? S_HIT : S_WSEND;
				end else begin
					state_d = S_FIN;
				end
			end
			S_RESP: begin
				if (sts.req_me) begin
					cmd.emit_sel = E_REPLY;
					if (sts.emit_ok) state_d = S_FIN;
				end else if (sts.is_reply && sts.peer_nz) begin
					state_d = S_WSCAN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_HIT: begin
				cmd.emit_sel = E_HIT;
				if (sts.emit_ok) state_d = S_FIN;
			end
			S_WSEND: begin
				cmd.emit_sel = sts.wq_free ? E_QUEUED : E_FULL;
				if (sts.emit_ok) state_d = (sts.wq_free && !sts.wq_req) ? S_WREQ : S_FIN;
			end
			S_WREQ: begin
				cmd.emit_sel = E_REQ;
				if (sts.emit_ok) state_d = S_FIN;
			end
			S_WSCAN: begin
				cmd.emit_sel = E_WAIT;
				cmd.w_step   = 1'b1;
				if (sts.w_go && sts.w_last) begin
					if (sts.is_tick) begin
						cmd.scan_start = 1'b1;
						state_d = S_CSCAN;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				if (sts.push_ok) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ sv/arpr_dp.sv @@
// ----------------------------------------------------------------------------
// arpr_dp: datapath of the ARP resolver
// Cache memory with scan pipe, wait queue, config registers, result regs.
// ----------------------------------------------------------------------------
module arpr_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pkt_take,
	input  arpr_pkg::item_t            pkt_item,
	input  logic                       cfg_we,
	input  logic [arpr_pkg::CFGI_W-1:0] cfg_idx,
	input  logic [arpr_pkg::CFGD_W-1:0] cfg_data,
	input  arpr_pkg::cmd_t             cmd,
	output arpr_pkg::sts_t             sts,
	input  logic                       res_ready,
	output logic                       res_valid,
	output arpr_pkg::res_t             res_item
);
	import arpr_pkg::*;

	localparam logic [CIDX_W-1:0] CLAST = CIDX_W'(CACHE_DEPTH - 1);
	localparam logic [WIDX_W-1:0] WLAST = WIDX_W'(WAIT_DEPTH - 1);
	localparam logic [4:0]        NPORTS_V = 5'(NUM_PORTS);

	item_t             item_q;
	logic [LIFE_W-1:0] lifetime_q;
	logic [TRY_W-1:0]  limit_q;
	logic [IVL_W-1:0]  interval_q;

	// cache
	centry_t           cmem [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] cv_q;
	logic [CIDX_W-1:0] ca_q;
	logic              issue_q;
	logic              rv_s1;
	logic [CIDX_W-1:0] ridx_s1;
	centry_t           rd_s1;
	logic              hit_q, free_q;
	logic [CIDX_W-1:0] hit_idx_q, free_idx_q, old_idx_q;
	logic [MAC_W-1:0]  hit_mac_q;
	logic [NOW_W-1:0]  old_age_q;
	logic [CIDX_W-1:0] wr_idx;
	logic [NOW_W-1:0]  c_age;
	logic              c_valid, c_ipeq;

	// wait queue
	logic [WAIT_DEPTH-1:0] wv_q;
	logic [IP_W-1:0]   wip_q   [WAIT_DEPTH];
	logic [PORT_W-1:0] wport_q [WAIT_DEPTH];
	logic [TAG_W-1:0]  wtag_q  [WAIT_DEPTH];
	logic [TRY_W-1:0]  wtry_q  [WAIT_DEPTH];
	logic [NOW_W-1:0]  wlast_q [WAIT_DEPTH];
	logic [WIDX_W-1:0] w_q;
	logic              wq_free, wq_req;
	logic [WIDX_W-1:0] wq_slot;
	logic              w_flush, w_due, w_drop, w_emit;

	// results
	logic stg_v_q, out_v_q;
	res_t stg_q, out_q, new_res, fin_res;
	logic push_ok, emit_ok, emit_fire, w_fire;

	// ---------------- item and config ----------------
	always_ff @(posedge clk) begin
		if (pkt_take) item_q <= pkt_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RST;
			limit_q    <= LIMIT_RST;
			interval_q <= INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LIFETIME: lifetime_q <= cfg_data;
				REG_LIMIT:    limit_q    <= cfg_data[TRY_W-1:0];
				REG_INTERVAL: interval_q <= cfg_data[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- cache scan ----------------
	assign c_valid = cv_q[ridx_s1];
	assign c_ipeq  = rd_s1.ip == item_q.peer_ip;
	assign c_age   = item_q.now - rd_s1.seen;
	assign wr_idx  = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);

	always_ff @(posedge clk) begin
		if (cmd.cache_write) cmem[wr_idx] <= '{ip: item_q.peer_ip, mac: item_q.peer_mac,
			seen: item_q.now};
		if (issue_q) rd_s1 <= cmem[ca_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_q    <= '0;
			issue_q <= 1'b0;
			rv_s1   <= 1'b0;
			ridx_s1 <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			cv_q    <= '0;
		end else begin
			rv_s1   <= issue_q;
			ridx_s1 <= ca_q;
			if (cmd.scan_start) begin
				issue_q <= 1'b1;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end else if (issue_q) begin
				if (ca_q == CLAST) begin
					ca_q    <= '0;
					issue_q <= 1'b0;
				end else begin
					ca_q <= ca_q + 1'b1;
				end
			end
			if (rv_s1) begin
				if (c_valid && c_ipeq && !hit_q) hit_q <= 1'b1;
				if (!c_valid && !free_q) free_q <= 1'b1;
				if (item_q.action == ACT_TICK && c_valid && c_age > {16'b0, lifetime_q})
					cv_q[ridx_s1] <= 1'b0;
			end
			if (cmd.cache_write) cv_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s1) begin
			if (c_valid && c_ipeq && !hit_q) begin
				hit_idx_q <= ridx_s1;
				hit_mac_q <= rd_s1.mac;
			end
			if (!c_valid && !free_q) free_idx_q <= ridx_s1;
			if (ridx_s1 == '0 || c_age > old_age_q) begin
				old_age_q <= c_age;
				old_idx_q <= ridx_s1;
			end
		end
	end

	// ---------------- wait queue ----------------
	always_comb begin
		wq_free = 1'b0;
		wq_req  = 1'b0;
		wq_slot = '0;
		for (int i = 0; i < WAIT_DEPTH; i++) begin
			if (wv_q[i] && wip_q[i] == item_q.peer_ip) wq_req = 1'b1;
			if (!wv_q[i] && !wq_free) begin
				wq_free = 1'b1;
				wq_slot = WIDX_W'(i);
			end
		end
	end

	assign w_flush = wv_q[w_q] && wip_q[w_q] == item_q.peer_ip;
	assign w_due   = wv_q[w_q] && (item_q.now - wlast_q[w_q]) >= {24'b0, interval_q};
	assign w_drop  = wtry_q[w_q] >= limit_q;
	assign w_emit  = (item_q.action == ACT_RX) ? w_flush : w_due;
	assign w_fire  = cmd.w_step && (!w_emit || emit_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_q <= '0;
			w_q  <= '0;
		end else begin
			if (w_fire) begin
				w_q <= (w_q == WLAST) ? '0 : w_q + 1'b1;
				if (w_emit && (item_q.action == ACT_RX || w_drop)) wv_q[w_q] <= 1'b0;
			end
			if (cmd.emit_sel == E_QUEUED && emit_ok) wv_q[wq_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (w_fire && w_emit && item_q.action != ACT_RX && !w_drop) begin
			wtry_q[w_q]  <= wtry_q[w_q] + 1'b1;
			wlast_q[w_q] <= item_q.now;
		end
		if (cmd.emit_sel == E_QUEUED && emit_ok) begin
			wip_q[wq_slot]   <= item_q.peer_ip;
			wport_q[wq_slot] <= item_q.port;
			wtag_q[wq_slot]  <= item_q.packet_tag;
			wtry_q[wq_slot]  <= TRY_W'(1);
			wlast_q[wq_slot] <= item_q.now;
		end
	end

	// ---------------- results ----------------
	always_comb begin
		new_res = '0;
		case (cmd.emit_sel)
			E_REPLY: new_res = '{kind: K_REPLY, port: item_q.port, mac: item_q.peer_mac,
				ip: item_q.peer_ip, tag: '0, last: 1'b0};
			E_HIT: new_res = '{kind: K_SEND_NOW, port: item_q.port, mac: hit_mac_q,
				ip: item_q.peer_ip, tag: item_q.packet_tag, last: 1'b0};
			E_QUEUED: new_res = '{kind: K_QUEUED, port: item_q.port, mac: '0,
				ip: item_q.peer_ip, tag: item_q.packet_tag, last: 1'b0};
			E_FULL: new_res = '{kind: K_DROP_FULL, port: item_q.port, mac: '0,
				ip: item_q.peer_ip, tag: item_q.packet_tag, last: 1'b0};
			E_REQ: new_res = '{kind: K_REQUEST, port: item_q.port, mac: '0,
				ip: item_q.peer_ip, tag: '0, last: 1'b0};
			E_WAIT: begin
				if (item_q.action == ACT_RX)
					new_res = '{kind: K_SEND_NOW, port: wport_q[w_q], mac: item_q.peer_mac,
						ip: item_q.peer_ip, tag: wtag_q[w_q], last: 1'b0};
				else if (w_drop)
					new_res = '{kind: K_DROP_UNRES, port: wport_q[w_q], mac: '0,
						ip: wip_q[w_q], tag: wtag_q[w_q], last: 1'b0};
				else
					new_res = '{kind: K_REQUEST, port: wport_q[w_q], mac: '0,
						ip: wip_q[w_q], tag: '0, last: 1'b0};
			end
			default: new_res = '0;
		endcase
	end

	// closing result: staged one, or an empty one, with last set
	always_comb begin
		fin_res      = stg_v_q ? stg_q : '0;
		fin_res.last = 1'b1;
	end

	assign push_ok   = !out_v_q || res_ready;
	assign emit_ok   = !stg_v_q || push_ok;
	assign emit_fire = emit_ok && cmd.emit_sel != E_NONE && (cmd.emit_sel != E_WAIT || w_emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				stg_v_q <= 1'b1;
				if (stg_v_q) out_v_q <= 1'b1;
				else if (res_ready) out_v_q <= 1'b0;
			end else if (cmd.finish && push_ok) begin
				stg_v_q <= 1'b0;
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			stg_q <= new_res;
			if (stg_v_q) out_q <= stg_q;
		end else if (cmd.finish && push_ok) begin
			out_q <= fin_res;
		end
	end

	assign res_valid = out_v_q;
	assign res_item  = out_q;

	// ---------------- status ----------------
	always_comb begin
		sts           = '0;
		sts.is_rx     = item_q.action == ACT_RX && item_q.item_ok &&
			{3'b0, item_q.port} < NPORTS_V;
		sts.is_tx     = item_q.action == ACT_TX && item_q.item_ok &&
			{3'b0, item_q.port} < NPORTS_V;
		sts.is_tick   = item_q.action == ACT_TICK;
		sts.peer_nz   = item_q.peer_ip != '0;
		sts.req_me    = item_q.opcode == OP_REQUEST && item_q.wanted_ip == item_q.port_ip;
		sts.is_reply  = item_q.opcode == OP_REPLY;
		sts.scan_done = rv_s1 && ridx_s1 == CLAST;
		sts.hit       = hit_q;
		sts.wq_free   = wq_free;
		sts.wq_req    = wq_req;
		sts.w_last    = w_q == WLAST;
		sts.w_go      = !w_emit || emit_ok;
		sts.emit_ok   = emit_ok;
		sts.push_ok   = push_ok;
	end

endmodule

@@ sv/arp_resolver_cache_and_pending_queue_top.sv @@
// ----------------------------------------------------------------------------
// arp_resolver_cache_and_pending_queue_top: ARP cache with pending queue
// Oldest-entry-replaced IP-to-MAC cache plus a queue of packets awaiting resolution.
// ----------------------------------------------------------------------------
// channel  dir  payload                                           handshake
// pkt      in   action now port port_ip peer_ip peer_mac          valid/ready
//               wanted_ip opcode item_ok packet_tag
// res      out  kind out_port dest_mac about_ip out_tag last      valid/ready
// cfg      in   index data (0 lifetime, 1 retry limit, 2 interval) valid/ready
//
// One item at a time. A send item, or a receive item with a nonzero sender,
// scans the 64-entry cache through the single memory read port, one entry a
// cycle; an ARP reply then also walks the 16-entry queue. A tick walks the
// queue, one entry a cycle unless a result stalls, then the cache. Reset
// clears the cache and queue valid flops at once; no clearing pass. A stalled
// result port holds the queue walk while a result waits; cfg is always ready.
module arp_resolver_cache_and_pending_queue_top (
	input logic        clk,
	input logic        arst_n,
	arpr_pkt_if.sink   pkt,
	arpr_res_if.source res,
	arpr_cfg_if.sink   cfg
);
	import arpr_pkg::*;

	cmd_t  cmd;
	sts_t  sts;
	item_t pkt_item;
	res_t  res_item;
	logic  pkt_ready;
	logic  res_valid;

	assign pkt_item = '{action: pkt.action, now: pkt.now, port: pkt.port,
		port_ip: pkt.port_ip, peer_ip: pkt.peer_ip, peer_mac: pkt.peer_mac,
		wanted_ip: pkt.wanted_ip, opcode: pkt.opcode, item_ok: pkt.item_ok,
		packet_tag: pkt.packet_tag};

	assign pkt.ready = pkt_ready;
	assign cfg.ready = 1'b1;

	arpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt.valid),
		.pkt_ready (pkt_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	arpr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_take  (pkt.valid && pkt_ready),
		.pkt_item  (pkt_item),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (res.ready),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	// result register straight to the port
	assign res.valid    = res_valid;
	assign res.kind     = res_item.kind;
	assign res.out_port = res_item.port;
	assign res.dest_mac = res_item.mac;
	assign res.about_ip = res_item.ip;
	assign res.out_tag  = res_item.tag;
	assign res.last     = res_item.last;

endmodule

@@ sv/arpr_chk.sv @@
// ----------------------------------------------------------------------------
// arpr_chk: port-level checks of the ARP resolver
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module arpr_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pkt_valid,
	input logic                        pkt_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [arpr_pkg::KIND_W-1:0] res_kind,
	input logic [arpr_pkg::TAG_W-1:0]  res_tag,
	input logic                        res_last,
	input logic                        cfg_ready
);
	import arpr_pkg::*;

	// a held result stays up
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// one item in flight: no back-to-back accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_ready |=> !pkt_ready)
		else $error("second item accepted during work");

	// an empty result always closes its item
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == K_NONE |-> res_last)
		else $error("empty result without last");

	// replies and requests carry no frame handle
	a_no_tag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == K_REPLY || res_kind == K_REQUEST) |-> res_tag == '0)
		else $error("tag on reply or request");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port stalled");

endmodule

bind arp_resolver_cache_and_pending_queue_top arpr_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.pkt_valid (pkt.valid),
	.pkt_ready (pkt.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_kind  (res.kind),
	.res_tag   (res.out_tag),
	.res_last  (res.last),
	.cfg_ready (cfg.ready)
);

@@ bench/tb_arp_resolver_cache_and_pending_queue_top.sv @@
// ----------------------------------------------------------------------------
// tb_arp_resolver_cache_and_pending_queue_top: ARP resolver testbench
// A clocked driver feeds items from a queue; a clocked monitor checks every
// result against an in-bench copy of the cache and the pending queue.
// ----------------------------------------------------------------------------
module tb_arp_resolver_cache_and_pending_queue_top;
	timeunit 1ns;
	timeprecision 1ps;
	import arpr_pkg::*;

	localparam int IDLE_CYCLES = 200;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

	logic clk;
	logic arst_n;

	arpr_pkt_if pkt();
	arpr_res_if res();
	arpr_cfg_if cfg();

	arp_resolver_cache_and_pending_queue_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// Predicted copy of the block's state
	// ------------------------------------------------------------------
	logic              c_valid [CACHE_DEPTH];
	logic [IP_W-1:0]   c_ip    [CACHE_DEPTH];
	logic [MAC_W-1:0]  c_mac   [CACHE_DEPTH];
	logic [NOW_W-1:0]  c_seen  [CACHE_DEPTH];
	logic              w_valid [WAIT_DEPTH];
	logic [IP_W-1:0]   w_ip    [WAIT_DEPTH];
	logic [PORT_W-1:0] w_port  [WAIT_DEPTH];
	logic [TAG_W-1:0]  w_tag   [WAIT_DEPTH];
	logic [TRY_W-1:0]  w_tries [WAIT_DEPTH];
	logic [NOW_W-1:0]  w_sent  [WAIT_DEPTH];
	logic [LIFE_W-1:0] lifetime;
	logic [TRY_W-1:0]  limit;
	logic [IVL_W-1:0]  interval;

	res_t   expected_results[$];   // results still owed by the block
	res_t   item_results[$];       // results of the item being predicted
	item_t  pending_items[$];      // items the driver has yet to offer
	int     fails;
	int     send_idle_pct;
	int     recv_stall_pct;
	bit     recv_hold;             // long receiver hold-off for back-pressure
	bit     pkt_took;              // item accepted at the last rising edge

	function automatic void add_result(logic [KIND_W-1:0] k, logic [PORT_W-1:0] p,
			logic [MAC_W-1:0] m, logic [IP_W-1:0] ip, logic [TAG_W-1:0] t);
		res_t r;
		if (item_results.size() >= 16)
			return;
		r.kind = k; r.port = p; r.mac = m; r.ip = ip; r.tag = t; r.last = 1'b0;
		item_results.push_back(r);
	endfunction

	function automatic int cache_find(logic [IP_W-1:0] ip);
		for (int i = 0; i < CACHE_DEPTH; i++)
			if (c_valid[i] && c_ip[i] == ip)
				return i;
		return -1;
	endfunction

	function automatic void cache_learn(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
			logic [NOW_W-1:0] now);
		int free_i;
		int old_i;
		logic [NOW_W-1:0] old_age;
		logic [NOW_W-1:0] age;
		int hit;
		free_i = -1;
		old_i = 0;
		old_age = '0;
		hit = cache_find(ip);
		if (hit >= 0) begin
			c_mac[hit] = mac;
			c_seen[hit] = now;
			return;
		end
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			age = now - c_seen[i];
			if (!c_valid[i] && free_i < 0)
				free_i = i;
			if (i == 0 || age > old_age) begin
				old_age = age;
				old_i = i;
			end
		end
		if (free_i < 0)
			free_i = old_i;
		c_valid[free_i] = 1'b1;
		c_ip[free_i] = ip;
		c_mac[free_i] = mac;
		c_seen[free_i] = now;
	endfunction

	// Works out the results of one accepted item and appends them.
	function automatic void predict_resolver(item_t it);
		int c;
		int slot;
		bit asked;
		bit port_ok;
		item_results.delete();
		port_ok = it.port < NUM_PORTS;
		if (it.action == ACT_RX && it.item_ok && port_ok) begin
			if (it.peer_ip != '0)
				cache_learn(it.peer_ip, it.peer_mac, it.now);
			if (it.opcode == OP_REQUEST && it.wanted_ip == it.port_ip) begin
				add_result(K_REPLY, it.port, it.peer_mac, it.peer_ip, '0);
			end else if (it.opcode == OP_REPLY) begin
				c = cache_find(it.peer_ip);
				if (c >= 0)
					for (int i = 0; i < WAIT_DEPTH; i++)
						if (w_valid[i] && w_ip[i] == it.peer_ip) begin
							add_result(K_SEND_NOW, w_port[i], c_mac[c], it.peer_ip, w_tag[i]);
							w_valid[i] = 1'b0;
						end
			end
		end else if (it.action == ACT_TX && it.item_ok && port_ok) begin
			c = cache_find(it.peer_ip);
			slot = -1;
			asked = 0;
			if (c >= 0) begin
				add_result(K_SEND_NOW, it.port, c_mac[c], it.peer_ip, it.packet_tag);
			end else begin
				for (int i = 0; i < WAIT_DEPTH; i++) begin
					if (w_valid[i] && w_ip[i] == it.peer_ip)
						asked = 1;
					if (!w_valid[i] && slot < 0)
						slot = i;
				end
				if (slot < 0) begin
					add_result(K_DROP_FULL, it.port, '0, it.peer_ip, it.packet_tag);
				end else begin
					w_valid[slot] = 1'b1;
					w_ip[slot] = it.peer_ip;
					w_port[slot] = it.port;
					w_tag[slot] = it.packet_tag;
					w_tries[slot] = TRY_W'(1);
					w_sent[slot] = it.now;
					add_result(K_QUEUED, it.port, '0, it.peer_ip, it.packet_tag);
					if (!asked)
						add_result(K_REQUEST, it.port, '0, it.peer_ip, '0);
				end
			end
		end else if (it.action == ACT_TICK) begin
			for (int i = 0; i < WAIT_DEPTH; i++) begin
				if (!w_valid[i] || NOW_W'(it.now - w_sent[i]) < NOW_W'(interval))
					continue;
				if (w_tries[i] >= limit) begin
					add_result(K_DROP_UNRES, w_port[i], '0, w_ip[i], w_tag[i]);
					w_valid[i] = 1'b0;
					continue;
				end
				w_tries[i] = w_tries[i] + 1'b1;
				w_sent[i] = it.now;
				add_result(K_REQUEST, w_port[i], '0, w_ip[i], '0);
			end
			for (int i = 0; i < CACHE_DEPTH; i++)
				if (c_valid[i] && NOW_W'(it.now - c_seen[i]) > NOW_W'(lifetime))
					c_valid[i] = 1'b0;
		end
		if (item_results.size() == 0)
			add_result(K_NONE, '0, '0, '0, '0);
		item_results[item_results.size()-1].last = 1'b1;
		foreach (item_results[i])
			expected_results.push_back(item_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers queued items at the falling edge, predicts on accept
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		pkt_took <= arst_n && pkt.valid && pkt.ready;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (pkt_took)
				predict_resolver(pending_items.pop_front());
			if (pending_items.size() > 0 && ((pkt.valid && !pkt_took) ||
					$urandom_range(99) >= send_idle_pct)) begin
				pkt.valid <= 1'b1;
				{pkt.action, pkt.now, pkt.port, pkt.port_ip, pkt.peer_ip, pkt.peer_mac,
					pkt.wanted_ip, pkt.opcode, pkt.item_ok, pkt.packet_tag}
					<= pending_items[0];
			end else begin
				pkt.valid <= 1'b0;
			end
			res.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted result against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result kind=%0d", res.kind);
				fails++;
			end else begin
				want = expected_results.pop_front();
				if (res.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, res.kind); fails++;
				end
				if (res.out_port !== want.port) begin
					$error("out_port: expected %0d, got %0d", want.port, res.out_port); fails++;
				end
				if (res.dest_mac !== want.mac) begin
					$error("dest_mac: expected %h, got %h", want.mac, res.dest_mac); fails++;
				end
				if (res.about_ip !== want.ip) begin
					$error("about_ip: expected %h, got %h", want.ip, res.about_ip); fails++;
				end
				if (res.out_tag !== want.tag) begin
					$error("out_tag: expected %h, got %h", want.tag, res.out_tag); fails++;
				end
				if (res.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, res.last); fails++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	logic [NOW_W-1:0] clock_now;   // running time of the stimulus
	logic [IP_W-1:0]  ip_pool[8];  // small set of next hops so hits happen

	function automatic item_t blank_item(logic [ACT_W-1:0] act);
		item_t it;
		it = '0;
		it.action = act;
		it.now = clock_now;
		it.item_ok = 1'b1;
		it.port_ip = 32'h0A00_0001;
		return it;
	endfunction

	task automatic queue_item(item_t it);
		pending_items.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || pkt.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_LIFETIME: lifetime = val;
			REG_LIMIT:    limit = val[TRY_W-1:0];
			REG_INTERVAL: interval = val[IVL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Random item, mostly well-formed traffic around the small IP pool.
	function automatic item_t random_item();
		item_t it;
		int sel;
		sel = $urandom_range(99);
		if ($urandom_range(3) == 0)
			clock_now = clock_now + $urandom_range(3);
		if (sel < 35) begin
			it = blank_item(ACT_TX);
			it.peer_ip = ip_pool[$urandom_range(7)];
			it.port = PORT_W'($urandom_range(3));
			it.packet_tag = TAG_W'($urandom);
		end else if (sel < 65) begin
			it = blank_item(ACT_RX);
			it.peer_ip = ip_pool[$urandom_range(7)];
			it.peer_mac = MAC_W'({$urandom, $urandom});
			it.port = PORT_W'($urandom_range(3));
			it.opcode = ($urandom_range(3) == 0) ? OP_REQUEST : OP_REPLY;
			it.wanted_ip = ($urandom_range(1) == 0) ? it.port_ip : $urandom;
		end else if (sel < 85) begin
			it = blank_item(ACT_TICK);
		end else begin
			// noise: all fields random, now sometimes kept current
			it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom});
			if ($urandom_range(1) == 0)
				it.now = clock_now;
		end
		return it;
	endfunction

	task automatic run_phase(int n, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++)
			queue_item(random_item());
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		item_t it;
		fails = 0;
		recv_hold = 0;
		pkt_took = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		clock_now = 32'd1000;
		pkt.valid = 1'b0;
		{pkt.action, pkt.now, pkt.port, pkt.port_ip, pkt.peer_ip, pkt.peer_mac,
			pkt.wanted_ip, pkt.opcode, pkt.item_ok, pkt.packet_tag} = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			c_valid[i] = 0; c_ip[i] = '0; c_mac[i] = '0; c_seen[i] = '0;
		end
		for (int i = 0; i < WAIT_DEPTH; i++) begin
			w_valid[i] = 0; w_ip[i] = '0; w_port[i] = '0; w_tag[i] = '0;
			w_tries[i] = '0; w_sent[i] = '0;
		end
		lifetime = LIFETIME_RST;
		limit = LIMIT_RST;
		interval = INTERVAL_RST;
		foreach (ip_pool[i])
			ip_pool[i] = 32'hC0A8_0000 | i;
		ip_pool[7] = 32'hFFFF_FFFF;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes of every field, each action and special case
		it = blank_item(ACT_TX);                   // miss: queued plus request
		it.peer_ip = ip_pool[1]; it.packet_tag = 16'hFFFF; it.port = 2'd3;
		queue_item(it);
		it.packet_tag = 16'h0001;                  // second waiter, no new request
		queue_item(it);
		it = blank_item(ACT_RX);                   // reply flushes both waiters
		it.peer_ip = ip_pool[1]; it.peer_mac = 48'hFFFF_FFFF_FFFF;
		it.opcode = OP_REPLY; it.port = 2'd3;
		queue_item(it);
		it = blank_item(ACT_TX);                   // hit: send at once
		it.peer_ip = ip_pool[1]; it.packet_tag = 16'h1234;
		queue_item(it);
		it = blank_item(ACT_RX);                   // request for us: reply
		it.peer_ip = 32'hFFFF_FFFF; it.peer_mac = 48'h0000_0000_0001;
		it.opcode = OP_REQUEST; it.wanted_ip = it.port_ip;
		queue_item(it);
		it.peer_ip = '0;                           // zero sender still answered
		queue_item(it);
		it.opcode = 16'hFFFF;                      // other op only learned
		it.peer_ip = 32'h0101_0101;
		queue_item(it);
		it.item_ok = 1'b0;                         // failed checks
		queue_item(it);
		it = blank_item(ACT_TX);
		it.item_ok = 1'b0;
		queue_item(it);
		it = blank_item(ACT_UNKNOWN);              // unknown action
		it.now = 32'hFFFF_FFFF;
		queue_item(it);
		for (int i = 0; i < WAIT_DEPTH + 1; i++) begin   // fill queue, then full drop
			it = blank_item(ACT_TX);
			it.peer_ip = 32'h0B00_0000 | i; it.packet_tag = TAG_W'(i);
			queue_item(it);
		end
		// now far ahead: retries, drops and whole-cache expiry; wraps time
		for (int i = 1; i <= 4; i++) begin
			clock_now = clock_now + 32'h7FFF_FFFF;
			queue_item(blank_item(ACT_TICK));
		end
		wait_drained();

		// Random phases under several register settings
		run_phase(50, 0, 0);
		write_reg(REG_LIFETIME, 16'd1);
		write_reg(REG_LIMIT, 16'd15);
		write_reg(REG_INTERVAL, 16'd255);
		run_phase(50, 60, 0);
		write_reg(REG_LIFETIME, 16'hFFFF);
		write_reg(REG_LIMIT, 16'd1);
		write_reg(REG_INTERVAL, 16'd1);
		run_phase(50, 0, 60);
		write_reg(REG_LIFETIME, 16'd5);
		write_reg(REG_LIMIT, 16'd2);
		write_reg(REG_INTERVAL, 16'd2);
		run_phase(50, 16, 16);

		// Back-pressure: receiver holds off while the sender keeps offering
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				recv_hold = 1;
				repeat (HOLD_CYCLES) @(posedge clk);
				recv_hold = 0;
			end
			for (int i = 0; i < 40; i++)
				queue_item(random_item());
		join
		wait_drained();

		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule
